/* hw/rtl/block_buffer_cache_lru_defines.svh */
// Assertion macros used by the buffer cache checker.
`ifndef BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bbc_pkg.sv */
// Types and constants of the block buffer cache.
package bbc_pkg;

  localparam int SLOT_W = 5;
  localparam int REF_W  = 8;
  localparam int DEV_W  = 8;
  localparam int BLK_W  = 32;
  localparam int TAG_W  = DEV_W + BLK_W;

  typedef enum logic [2:0] {
    CMD_GET     = 3'd0,
    CMD_MARK    = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_PIN     = 3'd3,
    CMD_UNPIN   = 3'd4
  } cmd_e;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_UNDER  = 2'd2;
  localparam logic [1:0] ST_OVER   = 2'd3;

  typedef struct packed {
    logic [2:0]        command;
    logic [DEV_W-1:0]  device_id;
    logic [BLK_W-1:0]  block_number;
    logic [SLOT_W-1:0] slot;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              hit;
    logic              needs_read;
    logic [REF_W-1:0]  ref_count_after;
    logic [1:0]        status;
  } out_t;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic update;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_get;
    logic scan_done;
    logic out_free;
  } ctl_sts_t;

endpackage

/* hw/rtl/block_buffer_cache_lru.sv */
// Top level of the block buffer cache tag manager.
// Each transaction returns exactly one result. A get walks the tag memory one slot per
// cycle, looking for a matching tag and for the least recently released free slot in
// the same pass; every other command skips the scan and goes straight to the update.
// One transaction is in work at a time; the result register lets the next transaction
// be accepted while a result still waits on a stalled output. No clearing pass is
// needed after reset.
module block_buffer_cache_lru #(
  parameter int SLOT_COUNT  = 32,
  parameter int COUNT_WIDTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bbc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bbc_pkg::out_t out_data
);

  bbc_pkg::ctl_cmd_t cmd;
  bbc_pkg::ctl_sts_t sts;

  bbc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd     (cmd),
    .sts     (sts)
  );

  bbc_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

/* hw/rtl/bbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

/* hw/rtl/bbc_ctrl.sv */
// Controller state machine of the block buffer cache.
module bbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output bbc_pkg::ctl_cmd_t cmd,
  input  bbc_pkg::ctl_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_UPDATE = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = sts.is_get ? S_SCAN : S_UPDATE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/bbc_datapath.sv */
// Slot table, tag memory, scan logic and result registers of the buffer cache.
module bbc_datapath #(
  parameter int SLOT_COUNT  = 32,
  parameter int COUNT_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bbc_pkg::in_t      in_data,
  input  bbc_pkg::ctl_cmd_t cmd,
  output bbc_pkg::ctl_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output bbc_pkg::out_t     out_data
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [IW:0] N_SLOTS = (IW + 1)'(SLOT_COUNT);

  bbc_pkg::in_t  req_r;
  bbc_pkg::out_t res_r, res_nxt;
  bbc_pkg::out_t out_r;
  logic          out_valid_r;

  logic          used_r  [SLOT_COUNT];
  logic          valid_r [SLOT_COUNT];
  logic [CW-1:0] cnt_r   [SLOT_COUNT];
  logic [IW-1:0] rank_r  [SLOT_COUNT];

  logic [IW:0]   scan_idx_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  logic          hit_found_r;
  logic [IW-1:0] hit_idx_r;
  logic          free_found_r;
  logic [IW-1:0] best_idx_r;
  logic [IW-1:0] best_rank_r;

  logic [bbc_pkg::TAG_W-1:0] tag_rdata;
  logic                      tag_we;
  logic                      scan_rd;

  logic          cnt_we;
  logic [IW-1:0] cnt_widx;
  logic [CW-1:0] cnt_wval;
  logic          claim;
  logic          set_valid;
  logic          to_front;
  logic [IW-1:0] sidx;
  logic          slot_ok;
  logic [CW-1:0] scnt;
  logic [CW-1:0] hcnt;
  logic          cmp_match;
  logic          cmp_free;

  assign scan_rd = cmd.scan_step && (scan_idx_r < N_SLOTS);
  assign tag_we  = cmd.update && claim;

  bbc_ram #(
    .WIDTH(bbc_pkg::TAG_W),
    .DEPTH(SLOT_COUNT)
  ) u_tag_ram (
    .clk    (clk),
    .we     (tag_we),
    .waddr  (best_idx_r),
    .wdata  ({req_r.device_id, req_r.block_number}),
    .re     (scan_rd),
    .raddr  (scan_idx_r[IW-1:0]),
    .rdata_r(tag_rdata)
  );

  assign sidx    = IW'(req_r.slot);
  assign slot_ok = ({2'b00, req_r.slot} < 7'(SLOT_COUNT));
  assign scnt    = cnt_r[sidx];
  assign hcnt    = cnt_r[hit_idx_r];

  assign cmp_match = used_r[cmp_idx_r] &&
                     (tag_rdata == {req_r.device_id, req_r.block_number});
  assign cmp_free  = (cnt_r[cmp_idx_r] == '0) &&
                     (!free_found_r || (rank_r[cmp_idx_r] > best_rank_r));

  assign sts.is_get    = (in_data.command == bbc_pkg::CMD_GET);
  assign sts.scan_done = (scan_idx_r == N_SLOTS) && !cmp_vld_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    res_nxt   = '0;
    cnt_we    = 1'b0;
    cnt_widx  = sidx;
    cnt_wval  = scnt;
    claim     = 1'b0;
    set_valid = 1'b0;
    to_front  = 1'b0;
    res_nxt.slot_out = req_r.slot;
    if (req_r.command == bbc_pkg::CMD_GET) begin
      if (hit_found_r) begin
        res_nxt.slot_out   = bbc_pkg::SLOT_W'(hit_idx_r);
        res_nxt.hit        = 1'b1;
        res_nxt.needs_read = !valid_r[hit_idx_r];
        cnt_widx = hit_idx_r;
        if (hcnt == CNT_MAX) begin
          res_nxt.status          = bbc_pkg::ST_OVER;
          res_nxt.ref_count_after = bbc_pkg::REF_W'(hcnt);
        end else begin
          cnt_we   = 1'b1;
          cnt_wval = hcnt + 1'b1;
          res_nxt.ref_count_after = bbc_pkg::REF_W'(cnt_wval);
        end
      end else if (free_found_r) begin
        claim    = 1'b1;
        cnt_we   = 1'b1;
        cnt_widx = best_idx_r;
        cnt_wval = CW'(1);
        res_nxt.slot_out        = bbc_pkg::SLOT_W'(best_idx_r);
        res_nxt.needs_read      = 1'b1;
        res_nxt.ref_count_after = bbc_pkg::REF_W'(1);
      end else begin
        res_nxt.slot_out = '0;
        res_nxt.status   = bbc_pkg::ST_NOFREE;
      end
    end else if (slot_ok) begin
      res_nxt.ref_count_after = bbc_pkg::REF_W'(scnt);
      unique case (req_r.command)
        bbc_pkg::CMD_MARK: set_valid = 1'b1;
        bbc_pkg::CMD_RELEASE, bbc_pkg::CMD_UNPIN: begin
          if (scnt == '0) begin
            res_nxt.status = bbc_pkg::ST_UNDER;
          end else begin
            cnt_we   = 1'b1;
            cnt_wval = scnt - 1'b1;
            to_front = (req_r.command == bbc_pkg::CMD_RELEASE) && (cnt_wval == '0);
            res_nxt.ref_count_after = bbc_pkg::REF_W'(cnt_wval);
          end
        end
        bbc_pkg::CMD_PIN: begin
          if (scnt == CNT_MAX) begin
            res_nxt.status = bbc_pkg::ST_OVER;
          end else begin
            cnt_we   = 1'b1;
            cnt_wval = scnt + 1'b1;
            res_nxt.ref_count_after = bbc_pkg::REF_W'(cnt_wval);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        used_r[i]  <= 1'b0;
        valid_r[i] <= 1'b0;
        cnt_r[i]   <= '0;
        rank_r[i]  <= IW'(SLOT_COUNT - 1 - i);
      end
    end else if (cmd.update) begin
      if (cnt_we) begin
        cnt_r[cnt_widx] <= cnt_wval;
      end
      if (claim) begin
        used_r[best_idx_r]  <= 1'b1;
        valid_r[best_idx_r] <= 1'b0;
      end
      if (set_valid) begin
        valid_r[sidx] <= 1'b1;
      end
      if (to_front) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (rank_r[i] < rank_r[sidx]) begin
            rank_r[i] <= rank_r[i] + 1'b1;
          end
        end
        rank_r[sidx] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      cmp_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        scan_idx_r   <= '0;
        cmp_vld_r    <= 1'b0;
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
      end else if (cmd.scan_step) begin
        cmp_vld_r <= scan_rd;
        if (scan_rd) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (cmp_vld_r) begin
          if (cmp_match && !hit_found_r) begin
            hit_found_r <= 1'b1;
          end
          if (cmp_free) begin
            free_found_r <= 1'b1;
          end
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (scan_rd) begin
      cmp_idx_r <= scan_idx_r[IW-1:0];
    end
    if (cmd.scan_step && cmp_vld_r) begin
      if (cmp_match && !hit_found_r) begin
        hit_idx_r <= cmp_idx_r;
      end
      if (cmp_free) begin
        best_idx_r  <= cmp_idx_r;
        best_rank_r <= rank_r[cmp_idx_r];
      end
    end
    if (cmd.update) begin
      res_r <= res_nxt;
    end
    if (cmd.emit) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hw/rtl/bbc_checker.sv */
// Port checker of the block buffer cache and its bind to the top level.
`include "block_buffer_cache_lru_defines.svh"

module bbc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input bbc_pkg::out_t out_data
);

  `BBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "Stalled result transaction changed.")
  `BBC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "Input not stalled while a transaction is in work.")
  `BBC_ASSERT_NOW(a_nofree_fields, clk, rst_n, out_valid && (out_data.status == bbc_pkg::ST_NOFREE), (out_data.slot_out == '0) && !out_data.hit && !out_data.needs_read && (out_data.ref_count_after == '0), "No-free result carries nonzero fields.")
  `BBC_ASSERT_NOW(a_miss_fill, clk, rst_n, out_valid && !out_data.hit && out_data.needs_read, (out_data.status == bbc_pkg::ST_OK) && (out_data.ref_count_after == 8'd1), "Miss result does not claim a slot with one reference.")

endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

/* tb/testbench.sv */
// Testbench for the block buffer cache tag manager, checked against a predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int NSLOT = 32;
  localparam int CMAX = 255;
  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  bbc_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  bbc_pkg::out_t out_data;

  block_buffer_cache_lru dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic        slot_used [NSLOT];
  logic [7:0]  slot_dev [NSLOT];
  logic [31:0] slot_blk [NSLOT];
  int          slot_refs [NSLOT];
  logic        slot_filled [NSLOT];
  int          slot_age [NSLOT];

  bbc_pkg::in_t  pending_cmds[$];
  bbc_pkg::out_t expected_results[$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   sender_hold = 0;
  int   long_stall = 0;
  int   send_gap = 0;
  int   recv_gap = 0;

  function automatic bbc_pkg::out_t mk(int s, bit h, bit rd, int c, logic [1:0] st);
    bbc_pkg::out_t r;
    r.slot_out = s[4:0];
    r.hit = h;
    r.needs_read = rd;
    r.ref_count_after = c[7:0];
    r.status = st;
    return r;
  endfunction

  function automatic bbc_pkg::out_t cache_apply(bbc_pkg::in_t c);
    int s;
    int best;
    int old;
    bit found;
    logic [1:0] st;
    s = c.slot;
    if (c.command == bbc_pkg::CMD_GET) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (slot_used[i] && slot_dev[i] == c.device_id &&
            slot_blk[i] == c.block_number) begin
          st = bbc_pkg::ST_OK;
          if (slot_refs[i] >= CMAX) st = bbc_pkg::ST_OVER;
          else slot_refs[i]++;
          return mk(i, 1'b1, !slot_filled[i], slot_refs[i], st);
        end
      end
      found = 0;
      best = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (slot_refs[i] == 0 && (!found || slot_age[i] > slot_age[best])) begin
          found = 1;
          best = i;
        end
      end
      if (!found) return mk(0, 1'b0, 1'b0, 0, bbc_pkg::ST_NOFREE);
      slot_used[best] = 1'b1;
      slot_dev[best] = c.device_id;
      slot_blk[best] = c.block_number;
      slot_filled[best] = 1'b0;
      slot_refs[best] = 1;
      return mk(best, 1'b0, 1'b1, 1, bbc_pkg::ST_OK);
    end
    if (s >= NSLOT) return mk(s, 1'b0, 1'b0, 0, bbc_pkg::ST_OK);
    case (c.command)
      bbc_pkg::CMD_MARK: begin
        slot_filled[s] = 1'b1;
        return mk(s, 1'b0, 1'b0, slot_refs[s], bbc_pkg::ST_OK);
      end
      bbc_pkg::CMD_RELEASE: begin
        if (slot_refs[s] == 0) return mk(s, 1'b0, 1'b0, 0, bbc_pkg::ST_UNDER);
        slot_refs[s]--;
        if (slot_refs[s] == 0) begin
          old = slot_age[s];
          for (int i = 0; i < NSLOT; i++) if (slot_age[i] < old) slot_age[i]++;
          slot_age[s] = 0;
        end
        return mk(s, 1'b0, 1'b0, slot_refs[s], bbc_pkg::ST_OK);
      end
      bbc_pkg::CMD_PIN: begin
        if (slot_refs[s] >= CMAX) begin
          return mk(s, 1'b0, 1'b0, slot_refs[s], bbc_pkg::ST_OVER);
        end
        slot_refs[s]++;
        return mk(s, 1'b0, 1'b0, slot_refs[s], bbc_pkg::ST_OK);
      end
      bbc_pkg::CMD_UNPIN: begin
        if (slot_refs[s] == 0) return mk(s, 1'b0, 1'b0, 0, bbc_pkg::ST_UNDER);
        slot_refs[s]--;
        return mk(s, 1'b0, 1'b0, slot_refs[s], bbc_pkg::ST_OK);
      end
      default: return mk(s, 1'b0, 1'b0, slot_refs[s], bbc_pkg::ST_OK);
    endcase
  endfunction

  function automatic bbc_pkg::in_t cmd(logic [2:0] op, logic [7:0] d, logic [31:0] b,
                                       logic [4:0] s);
    bbc_pkg::in_t c;
    c.command = op;
    c.device_id = d;
    c.block_number = b;
    c.slot = s;
    return c;
  endfunction

  task automatic report(string what, bbc_pkg::out_t got, bbc_pkg::out_t want);
    $display("mismatch in %s: got %p expected %p", what, got, want);
    errors++;
  endtask

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      expected_results.push_back(cache_apply(in_data));
      send_gap = $urandom_range(0, 8);
      if (send_gap == 0 && pending_cmds.size() > 0 && !sender_hold) begin
        in_data <= pending_cmds.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (send_gap > 0) send_gap--;
      else if (pending_cmds.size() > 0 && !sender_hold) begin
        in_data <= pending_cmds.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result %p", out_data);
          errors++;
        end else if (out_data !== expected_results[0]) begin
          report("result", out_data, expected_results[0]);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if (long_stall > 0) begin
        long_stall--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall) recv_gap = $urandom_range(0, 8);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_cmds.size() == 0 && expected_results.size() == 0 && !in_valid))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_random(int n, bit calm);
    int r;
    logic [7:0] d;
    logic [31:0] b;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      d = 8'($urandom_range(0, 3));
      b = $urandom_range(0, 40);
      if (r < 5) b = $urandom;
      if (r < 3) d = 8'($urandom);
      if (calm) r = $urandom_range(0, 79);
      if (r < 35) begin
        pending_cmds.push_back(cmd(bbc_pkg::CMD_GET, d, b, 5'($urandom)));
      end else if (r < 50) begin
        pending_cmds.push_back(cmd(bbc_pkg::CMD_MARK, 8'($urandom), $urandom,
                                   5'($urandom_range(0, 31))));
      end else if (r < 75) begin
        pending_cmds.push_back(cmd(bbc_pkg::CMD_RELEASE, 8'($urandom), $urandom,
                                   5'($urandom_range(0, 31))));
      end else if (r < 82) begin
        pending_cmds.push_back(cmd(bbc_pkg::CMD_PIN, 8'($urandom), $urandom,
                                   5'($urandom_range(0, 31))));
      end else if (r < 92) begin
        pending_cmds.push_back(cmd(bbc_pkg::CMD_UNPIN, 8'($urandom), $urandom,
                                   5'($urandom_range(0, 31))));
      end else begin
        pending_cmds.push_back(cmd(3'($urandom_range(5, 7)), 8'($urandom), $urandom,
                                   5'($urandom)));
      end
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = 0; slot_dev[i] = 0; slot_blk[i] = 0;
      slot_refs[i] = 0; slot_filled[i] = 0; slot_age[i] = NSLOT - 1 - i;
    end
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    pending_cmds.push_back(cmd(bbc_pkg::CMD_GET, 8'hff, 32'hffffffff, 5'd0));
    pending_cmds.push_back(cmd(bbc_pkg::CMD_GET, 8'hff, 32'hffffffff, 5'd31));
    pending_cmds.push_back(cmd(bbc_pkg::CMD_MARK, 8'd0, 32'd0, 5'd31));
    pending_cmds.push_back(cmd(bbc_pkg::CMD_GET, 8'hff, 32'hffffffff, 5'd0));
    pending_cmds.push_back(cmd(bbc_pkg::CMD_RELEASE, 8'd0, 32'd0, 5'd31));
    pending_cmds.push_back(cmd(bbc_pkg::CMD_RELEASE, 8'd0, 32'd0, 5'd5));
    pending_cmds.push_back(cmd(bbc_pkg::CMD_UNPIN, 8'd0, 32'd0, 5'd5));
    pending_cmds.push_back(cmd(bbc_pkg::CMD_PIN, 8'd0, 32'd0, 5'd7));
    pending_cmds.push_back(cmd(bbc_pkg::CMD_UNPIN, 8'd0, 32'd0, 5'd7));
    pending_cmds.push_back(cmd(3'd5, 8'd0, 32'd0, 5'd31));
    pending_cmds.push_back(cmd(3'd7, 8'd0, 32'd0, 5'd0));
    pending_cmds.push_back(cmd(bbc_pkg::CMD_GET, 8'h00, 32'h0, 5'd0));
    drain();
    // Pin one slot to saturation with one pin past the maximum, then push a hit on another slot.
    for (int i = 0; i < 256; i++) begin
      pending_cmds.push_back(cmd(bbc_pkg::CMD_PIN, 8'd0, 32'd0, 5'd3));
    end
    pending_cmds.push_back(cmd(bbc_pkg::CMD_GET, 8'h00, 32'h0, 5'd0));
    drain();
    // Claim every free slot; the misses after that find none free.
    for (int i = 0; i < 33; i++) begin
      pending_cmds.push_back(cmd(bbc_pkg::CMD_GET, 8'h10, 32'(i), 5'd0));
    end
    pending_cmds.push_back(cmd(bbc_pkg::CMD_GET, 8'h10, 32'h0, 5'd0));
    for (int i = 0; i < 32; i++) begin
      pending_cmds.push_back(cmd(bbc_pkg::CMD_RELEASE, 8'd0, 32'd0, 5'(i)));
    end
    drain();

    sender_hold = 1;
    @(posedge clk);
    long_stall = 300;
    add_random(12, 1);
    sender_hold = 0;
    drain();

    for (int p = 0; p < 15; p++) begin
      add_random(88, p % 3 == 0);
      drain();
      if (p % 5 == 4) begin
        for (int i = 0; i < 32; i++) begin
          pending_cmds.push_back(cmd(bbc_pkg::CMD_UNPIN, 8'd0, 32'd0, 5'(i)));
        end
        for (int i = 0; i < 32; i++) begin
          pending_cmds.push_back(cmd(bbc_pkg::CMD_RELEASE, 8'd0, 32'd0, 5'(i)));
        end
        drain();
      end
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_ram.sv
hw/rtl/bbc_ctrl.sv
hw/rtl/bbc_datapath.sv
hw/rtl/block_buffer_cache_lru.sv
hw/rtl/bbc_checker.sv
tb/testbench.sv
